// ===== hdl/psz_pkg.sv =====
// ----------------------------------------------------------------------------
// psz_pkg: shared types and constants of the planar safety zone damper
// Register indexes, payload layouts and the stage-to-stage bundle.
// ----------------------------------------------------------------------------
package psz_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 3'd6;

  // Stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_FIELD_W = 82;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Bit positions of the result fields inside m_tdata
  localparam int FX_LSB    = 0;
  localparam int FY_LSB    = 24;
  localparam int ACT_BIT   = 48;
  localparam int CROSS_BIT = 49;
  localparam int TOT_LSB   = 50;
  localparam int TOT_W     = 32;

  // Fixed-point constants
  localparam logic signed [15:0] VEL_BAD_POS = 16'sd20480;   // 5 m/s in Q3.12
  localparam logic signed [15:0] VEL_BAD_NEG = -16'sd20480;
  localparam logic signed [23:0] FORCE_MAX   = 24'sh7FFFFF;
  localparam logic signed [23:0] FORCE_MIN   = 24'sh800000;

  typedef struct packed {
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_y;
    logic        [14:0] speed_limit;
    logic        [15:0] damping_gain;
    logic               bypass;
  } cfg_t;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic signed [23:0] req_force_y;
    logic signed [23:0] req_force_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } in_item_t;

  // Registered products and early decisions for one tick
  typedef struct packed {
    logic        [30:0] sq_x;
    logic        [30:0] sq_y;
    logic        [29:0] lim_sq;
    logic signed [32:0] prod_x;
    logic signed [32:0] prod_y;
    logic               box_hit;
    logic               vel_bad;
    logic signed [23:0] req_force_x;
    logic signed [23:0] req_force_y;
  } prod_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic        [31:0] applied_total;
    logic               crossed_back;
    logic               damping_active;
    logic signed [23:0] force_y;
    logic signed [23:0] force_x;
  } res_t;

endpackage

// ===== hdl/psz_cfg.sv =====
// ----------------------------------------------------------------------------
// psz_cfg: configuration registers
// Write-only register file holding the safe box, speed limit, gain and bypass.
// ----------------------------------------------------------------------------
module psz_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psz_pkg::CFG_DATA_W-1:0] cfg_data,
  output psz_pkg::cfg_t                  cfg
);
  import psz_pkg::*;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_min_x    <= -16'sd32768;
      cfg.box_max_x    <= 16'sd32767;
      cfg.box_min_y    <= -16'sd32768;
      cfg.box_max_y    <= 16'sd32767;
      cfg.speed_limit  <= 15'h7FFF;
      cfg.damping_gain <= 16'h0000;
      cfg.bypass       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X:    cfg.box_min_x    <= $signed(cfg_data);
        REG_BOX_MAX_X:    cfg.box_max_x    <= $signed(cfg_data);
        REG_BOX_MIN_Y:    cfg.box_min_y    <= $signed(cfg_data);
        REG_BOX_MAX_Y:    cfg.box_max_y    <= $signed(cfg_data);
        REG_SPEED_LIMIT:  cfg.speed_limit  <= cfg_data[14:0];
        REG_DAMPING_GAIN: cfg.damping_gain <= cfg_data;
        REG_BYPASS:       cfg.bypass       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/psz_prod.sv =====
// ----------------------------------------------------------------------------
// psz_prod: product stage
// Squares the velocities and the speed limit, forms gain times velocity and
// evaluates the box and bad-sensor compares into the stage register.
// ----------------------------------------------------------------------------
module psz_prod (
  input  logic               clk,
  input  logic               rst,
  input  psz_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  psz_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output psz_pkg::prod_t     prod
);
  import psz_pkg::*;

  logic signed [31:0] sq_x_full;
  logic signed [31:0] sq_y_full;
  logic        [29:0] lim_sq_full;
  logic signed [32:0] prod_x_full;
  logic signed [32:0] prod_y_full;
  logic               box_hit;
  logic               vel_bad;
  logic               load;

  // The stage takes a new transaction when it is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // One multiply per quantity, all independent.
  always_comb begin
    sq_x_full   = 32'(in_item.vel_x) * 32'(in_item.vel_x);
    sq_y_full   = 32'(in_item.vel_y) * 32'(in_item.vel_y);
    lim_sq_full = 30'(cfg.speed_limit) * 30'(cfg.speed_limit);
    prod_x_full = 33'($signed({1'b0, cfg.damping_gain})) * 33'(in_item.vel_x);
    prod_y_full = 33'($signed({1'b0, cfg.damping_gain})) * 33'(in_item.vel_y);
  end

  // Touching a box edge counts as leaving the box.
  always_comb begin
    box_hit = (in_item.pos_x <= cfg.box_min_x) || (in_item.pos_x >= cfg.box_max_x) ||
              (in_item.pos_y <= cfg.box_min_y) || (in_item.pos_y >= cfg.box_max_y);
    vel_bad = (in_item.vel_x <= VEL_BAD_NEG) || (in_item.vel_x >= VEL_BAD_POS) ||
              (in_item.vel_y <= VEL_BAD_NEG) || (in_item.vel_y >= VEL_BAD_POS);
  end

  // Stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      prod.sq_x        <= sq_x_full[30:0];
      prod.sq_y        <= sq_y_full[30:0];
      prod.lim_sq      <= lim_sq_full;
      prod.prod_x      <= prod_x_full;
      prod.prod_y      <= prod_y_full;
      prod.box_hit     <= box_hit;
      prod.vel_bad     <= vel_bad;
      prod.req_force_x <= in_item.req_force_x;
      prod.req_force_y <= in_item.req_force_y;
    end
  end

endmodule

// ===== hdl/psz_decide.sv =====
// ----------------------------------------------------------------------------
// psz_decide: decision and result stage
// Finishes the speed test, selects damping, pass-through or zero force,
// updates the damping history and count, and holds the result register.
// ----------------------------------------------------------------------------
module psz_decide (
  input  logic            clk,
  input  logic            rst,
  input  psz_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  psz_pkg::prod_t  prod,
  output logic            out_valid,
  input  logic            out_ready,
  output psz_pkg::res_t   res
);
  import psz_pkg::*;

  logic        was_damping;
  logic [31:0] applied_count;

  logic        was_damping_next;
  logic [31:0] applied_count_next;
  logic [31:0] sq_sum;
  logic        hit;
  logic        active;
  logic        crossed;
  logic signed [23:0] force_x_next;
  logic signed [23:0] force_y_next;
  logic        load;

  // Negate, round to nearest with halves up, drop 8 fraction bits, saturate.
  function automatic logic signed [23:0] damp_force(input logic signed [32:0] p);
    logic signed [33:0] neg;
    logic signed [33:0] shifted;
    neg     = -{p[32], p} + 34'sd128;
    shifted = neg >>> 8;
    if (shifted > $signed({{10{FORCE_MAX[23]}}, FORCE_MAX})) begin
      damp_force = FORCE_MAX;
    end else if (shifted < $signed({{10{FORCE_MIN[23]}}, FORCE_MIN})) begin
      damp_force = FORCE_MIN;
    end else begin
      damp_force = shifted[23:0];
    end
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Speed test on squared magnitudes.
  assign sq_sum = {1'b0, prod.sq_x} + {1'b0, prod.sq_y};
  assign hit    = prod.box_hit || (sq_sum >= {2'b00, prod.lim_sq});

  // Force selection and state update for the current tick.
  always_comb begin
    active             = 1'b0;
    crossed            = 1'b0;
    force_x_next       = prod.req_force_x;
    force_y_next       = prod.req_force_y;
    was_damping_next   = was_damping;
    applied_count_next = applied_count;
    if (!cfg.bypass) begin
      if (hit) begin
        active           = 1'b1;
        force_x_next     = damp_force(prod.prod_x);
        force_y_next     = damp_force(prod.prod_y);
        was_damping_next = 1'b1;
        if (applied_count != 32'hFFFF_FFFF) begin
          applied_count_next = applied_count + 32'd1;
        end
      end else begin
        crossed          = was_damping;
        was_damping_next = 1'b0;
        if (prod.vel_bad) begin
          force_x_next = '0;
          force_y_next = '0;
        end
      end
    end
  end

  // History state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      was_damping   <= 1'b0;
      applied_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        was_damping   <= was_damping_next;
        applied_count <= applied_count_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res.force_x        <= force_x_next;
      res.force_y        <= force_y_next;
      res.damping_active <= active;
      res.crossed_back   <= crossed;
      res.applied_total  <= applied_count_next;
    end
  end

endmodule

// ===== hdl/planar_safety_zone_damper_top.sv =====
// ----------------------------------------------------------------------------
// planar_safety_zone_damper_top: planar safety zone damper
// Each control tick on the slave stream gives one force result on the master
// stream. Outside the safe box, or at or above the speed limit, the force is
// replaced by a velocity-proportional damping force and the controller is
// told to stop; otherwise the requested force passes, zeroed for an
// implausible velocity reading; in bypass the requested force always passes.
//
// Usage: a tick is one s_tdata transaction; its result is one m_tdata
// transaction, in order. Configuration is written through cfg_we, cfg_index
// and cfg_data while no tick is in flight.
// Pipeline: the product register loads at the edge that takes a tick, and the
// result register loads from it once the result stage can take it.
// Throughput: one tick per cycle while m_tready stays high; both stages
// register their outputs, so ticks follow each other back to back.
// Reset: rst clears the pipeline, the damping history and the applied count,
// and loads the register defaults (full box, top speed limit, zero gain).
// Stall: while m_tready is low the result is held; the product stage takes
// one more tick only when empty; then s_tready stays low until results drain.
// ----------------------------------------------------------------------------
module planar_safety_zone_damper_top (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [psz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psz_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Tick input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: pos_x[15:0], pos_y[31:16], vel_x[47:32], vel_y[63:48],
  //          req_force_x[87:64], req_force_y[111:88]
  input  logic [psz_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Force result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: force_x[23:0], force_y[47:24], damping_active[48],
  //          crossed_back[49], applied_total[81:50], zero pad[87:82]
  output logic [psz_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import psz_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  prod_t    prod;
  res_t     res;
  logic     prod_valid;
  logic     prod_ready;

  assign in_item = s_tdata;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, res};

  // Configuration registers
  psz_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Multiply and compare stage
  psz_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .prod      (prod)
  );

  // Decision and result stage
  psz_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .prod      (prod),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

endmodule

// ===== hdl/psz_checker.sv =====
// ----------------------------------------------------------------------------
// psz_checker: port-level checks of the safety zone damper
// Watches the result stream for consistent flags and a monotonic count.
// ----------------------------------------------------------------------------
module psz_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [psz_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import psz_pkg::*;

  logic [TOT_W-1:0] last_total;
  logic [TOT_W-1:0] cur_total;
  logic             out_xfer;

  assign cur_total = m_tdata[TOT_LSB +: TOT_W];
  assign out_xfer  = m_tvalid && m_tready;

  // Count seen in the previous result transaction; reset matches the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (out_xfer) begin
      last_total <= cur_total;
    end
  end

  // A result cannot both damp and report leaving damping.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[ACT_BIT] && m_tdata[CROSS_BIT]))
    else $error("damping_active and crossed_back both set");

  // A damped tick advances the count by one unless it is saturated.
  assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tdata[ACT_BIT]) |->
      ((cur_total == last_total + 32'd1) ||
       ((last_total == 32'hFFFF_FFFF) && (cur_total == last_total))))
    else $error("applied_total did not advance on a damped tick");

  // An undamped tick leaves the count where it was.
  assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !m_tdata[ACT_BIT]) |-> (cur_total == last_total))
    else $error("applied_total changed on an undamped tick");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind planar_safety_zone_damper_top psz_checker u_psz_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
